/* hdl/brfifo_pkg.sv */
// Shared types and constants of the byte ring FIFO with pattern search.
package brfifo_pkg;

   // Operation codes carried by req_op
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_FLUSH = 2'd2,
      OP_MATCH = 2'd3
   } op_type;

   // Jump modes applied after a successful match; the fourth code keeps contents
   localparam logic [1:0] JUMP_KEEP    = 2'd0;
   localparam logic [1:0] JUMP_BEFORE  = 2'd1;
   localparam logic [1:0] JUMP_THROUGH = 2'd2;

   // Register map: one 64-bit slot per register, index in paddr[4:3]
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam logic [1:0] CSR_PATTERN = 2'd0;
   localparam logic [1:0] CSR_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_JUMP    = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SCAN_ADDR,
      ST_SCAN_CMP
   } state_type;

endpackage

/* hdl/byte_ring_fifo_with_pattern_search_unit.sv */
// Byte ring FIFO with a sequenced pattern search over the stored bytes.
//
// Byte ring FIFO of DEPTH entries held in one single-port-read memory. Each
// word on the req channel is one operation: push, pop, flush or match, and
// each produces exactly one word on the rsp channel carrying the status,
// the popped byte or the match position, and the fill level after the
// operation. Push, flush and a pop on an empty FIFO finish without leaving
// ST_IDLE, so they can be issued back to back while no result is parked. A
// pop that returns data passes through ST_POP_WAIT because the memory read
// data is registered. Match walks the stored bytes oldest first with one
// shared byte comparator: each byte is addressed in ST_SCAN_ADDR, then
// compared against the registered read data in ST_SCAN_CMP; a mismatch
// restarts at the next start position. req_stall stays high while an
// operation is in flight. A finished result waits in the rsp output
// register; one more operation may be accepted and completed behind it into
// a single holding slot. Pattern, pattern length and jump mode are written
// over the APB-style port (64-bit slots at byte addresses 0, 8 and 16); the
// user must write them only while the block is idle, which the block itself
// does not enforce. The byte store has no reset; the read/write pointers,
// fill level, sequencer state, valid flags and configuration registers clear.
module byte_ring_fifo_with_pattern_search_unit
   import brfifo_pkg::*;
#(
   parameter int DEPTH       = 256,
   parameter int PATTERN_MAX = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // Operation channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [7:0]                    req_data,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [7:0]                    rsp_read_byte,
   output logic [$clog2(DEPTH)-1:0]      rsp_match_offset,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_used_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full,
   output logic                          rsp_half_full,
   // Configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   // Room for scan start plus pattern length
   localparam int SUM_W  = ((CNT_W > 4) ? CNT_W : 4) + 1;

   typedef struct packed {
      logic              ok;
      logic [7:0]        read_byte;
      logic [ADDR_W-1:0] match_offset;
      logic [CNT_W-1:0]  used_count;
      logic              is_empty;
      logic              is_full;
      logic              half_full;
   } res_type;

   // Advance a ring position by one, wrapping at DEPTH
   function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] p);
      ring_inc = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [63:0]      pattern_ff;
   logic [3:0]       length_ff;
   logic [1:0]       jump_ff;
   logic             csr_wr;
   logic [1:0]       csr_index;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= 4'd1;
         jump_ff    <= JUMP_KEEP;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_PATTERN: pattern_ff <= pwdata;
            CSR_LENGTH:  length_ff  <= pwdata[3:0];
            CSR_JUMP:    jump_ff    <= pwdata[1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_PATTERN: prdata = pattern_ff;
         CSR_LENGTH:  prdata = {60'd0, length_ff};
         CSR_JUMP:    prdata = {62'd0, jump_ff};
         default:     prdata = '0;
      endcase
   end

   // Clamp the pattern length into 1..PATTERN_MAX
   logic [3:0] plen_sat;
   always_comb begin
      if (length_ff == 4'd0) begin
         plen_sat = 4'd1;
      end else if (length_ff > 4'(PATTERN_MAX)) begin
         plen_sat = 4'(PATTERN_MAX);
      end else begin
         plen_sat = length_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Ring state and scan registers
   // ---------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] rp_ff, rp_in;         // oldest byte
   logic [ADDR_W-1:0] wp_ff, wp_in;         // next free slot
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;       // current scan start
   logic [ADDR_W-1:0] probe_ff, probe_in;   // byte under compare
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [2:0]        k_ff, k_in;
   logic [3:0]        plen_ff, plen_in;

   // Byte store
   logic [7:0]        mem [DEPTH];
   logic [7:0]        mem_rd_data_ff;
   logic              mem_we;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;

   // Result path
   res_type           fin;
   logic              fin_valid;
   res_type           rsp_ff, rsp_in, pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in, pend_valid_ff, pend_valid_in;
   logic              out_free;

   logic              accept;
   op_type            op;
   logic              scan_over;
   logic              byte_hit;
   logic              byte_last;
   logic [SUM_W-1:0]  scan_end;
   logic [ADDR_W-1:0] after_pos;

   // Hold new work while an operation is in flight or a result is parked
   assign req_stall = (state_ff != ST_IDLE) || pend_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign op        = op_type'(req_op);

   // Shared compare unit: one pattern byte against the registered read data
   assign scan_end  = SUM_W'(scan_cnt_ff) + SUM_W'(plen_ff);
   assign scan_over = scan_end > SUM_W'(fill_ff);
   assign byte_hit  = mem_rd_data_ff == pattern_ff[8*k_ff +: 8];
   assign byte_last = k_ff == 3'(plen_ff - 4'd1);
   assign after_pos = ring_inc(probe_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && op == OP_POP && fill_ff != '0) begin
               state_in = ST_POP_WAIT;
            end else if (accept && op == OP_MATCH) begin
               state_in = ST_SCAN_ADDR;
            end
         end
         ST_POP_WAIT: begin
            state_in = ST_IDLE;
         end
         ST_SCAN_ADDR: begin
            state_in = scan_over ? ST_IDLE : ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            state_in = (byte_hit && byte_last) ? ST_IDLE : ST_SCAN_ADDR;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and sequencer outputs
   always_comb begin
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      ptr_in      = ptr_ff;
      probe_in    = probe_ff;
      scan_cnt_in = scan_cnt_ff;
      k_in        = k_ff;
      plen_in     = plen_ff;
      mem_we      = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = probe_ff;
      fin         = '0;
      fin_valid   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_PUSH: begin
                     fin_valid = 1'b1;
                     if (fill_ff != CNT_W'(DEPTH)) begin
                        mem_we  = 1'b1;
                        wp_in   = ring_inc(wp_ff);
                        fill_in = fill_ff + 1'b1;
                        fin.ok  = 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (fill_ff == '0) begin
                        fin_valid = 1'b1;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = rp_ff;
                     end
                  end
                  OP_FLUSH: begin
                     // Empty out but keep the read position
                     fin_valid = 1'b1;
                     fin.ok    = 1'b1;
                     fill_in   = '0;
                     wp_in     = rp_ff;
                  end
                  default: begin
                     ptr_in      = rp_ff;
                     probe_in    = rp_ff;
                     scan_cnt_in = '0;
                     k_in        = '0;
                     plen_in     = plen_sat;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            fin_valid     = 1'b1;
            fin.ok        = 1'b1;
            fin.read_byte = mem_rd_data_ff;
            rp_in         = ring_inc(rp_ff);
            fill_in       = fill_ff - 1'b1;
         end
         ST_SCAN_ADDR: begin
            if (scan_over) begin
               fin_valid = 1'b1;
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         ST_SCAN_CMP: begin
            if (byte_hit) begin
               if (byte_last) begin
                  fin_valid        = 1'b1;
                  fin.ok           = 1'b1;
                  fin.match_offset = ptr_ff;
                  case (jump_ff)
                     JUMP_BEFORE: begin
                        rp_in   = ptr_ff;
                        fill_in = fill_ff - scan_cnt_ff;
                     end
                     JUMP_THROUGH: begin
                        fin.match_offset = after_pos;
                        rp_in            = after_pos;
                        fill_in          = fill_ff - CNT_W'(scan_end);
                     end
                     default: ;
                  endcase
               end else begin
                  k_in     = k_ff + 1'b1;
                  probe_in = after_pos;
               end
            end else begin
               // Mismatch: restart at the next start position
               scan_cnt_in = scan_cnt_ff + 1'b1;
               ptr_in      = ring_inc(ptr_ff);
               probe_in    = ring_inc(ptr_ff);
               k_in        = '0;
            end
         end
         default: ;
      endcase

      fin.used_count = fill_in;
      fin.is_empty   = fill_in == '0;
      fin.is_full    = fill_in == CNT_W'(DEPTH);
      fin.half_full  = fill_in >= CNT_W'(DEPTH / 2);
   end

   // Output register plus one holding slot behind it
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            rsp_in        = pend_ff;
            rsp_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else begin
            rsp_in       = fin;
            rsp_valid_in = fin_valid;
         end
      end else if (fin_valid) begin
         pend_in       = fin;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rp_ff         <= '0;
         wp_ff         <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      probe_ff    <= probe_in;
      scan_cnt_ff <= scan_cnt_in;
      k_ff        <= k_in;
      plen_ff     <= plen_in;
      rsp_ff      <= rsp_in;
      pend_ff     <= pend_in;
   end

   // Byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= req_data;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= mem[mem_rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ff.ok;
   assign rsp_read_byte    = rsp_ff.read_byte;
   assign rsp_match_offset = rsp_ff.match_offset;
   assign rsp_used_count   = rsp_ff.used_count;
   assign rsp_is_empty     = rsp_ff.is_empty;
   assign rsp_is_full      = rsp_ff.is_full;
   assign rsp_half_full    = rsp_ff.half_full;

`ifndef SYNTHESIS
   // Write pointer always sits fill bytes past the read pointer
   a_wp_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      int'(wp_ff) == ((int'(rp_ff) + int'(fill_ff) >= DEPTH)
                      ? int'(rp_ff) + int'(fill_ff) - DEPTH
                      : int'(rp_ff) + int'(fill_ff)))
      else $error("write pointer out of step with read pointer and fill");

   // A parked result implies the output register is occupied
   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("holding slot filled while output register empty");

   // An accepted match always starts the scan
   a_match_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_MATCH) |=> (state_ff == ST_SCAN_ADDR))
      else $error("match accepted without entering scan");
`endif

endmodule
